// File: sv/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and codes for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int unsigned DEFAULT_SLOTS = 64;

  localparam logic [1:0] OP_PLACE  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_PRUNE  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] TIF_IOC = 2'd1;
  localparam logic [1:0] TIF_FOK = 2'd2;

  localparam logic [1:0] KIND_FILL     = 2'd0;
  localparam logic [1:0] KIND_NO_FILL  = 2'd1;
  localparam logic [1:0] KIND_CANCEL   = 2'd2;
  localparam logic [1:0] KIND_PRUNE    = 2'd3;

  typedef enum logic [1:0] {
    SCAN_MATCH  = 2'd0,
    SCAN_CANCEL = 2'd1,
    SCAN_FREE   = 2'd2
  } scan_mode_e;

  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_DEC   = 3'd1,
    WR_CLEAR = 3'd2,
    WR_LOAD  = 3'd3,
    WR_PRUNE = 3'd4
  } wr_op_e;

  // search key broadcast to every cell
  typedef struct packed {
    scan_mode_e  mode;
    logic        side;
    logic [31:0] limit;
    logic [63:0] oid;
    logic [63:0] owner_high;
    logic [63:0] owner_middle;
    logic [31:0] owner_low;
  } key_t;

  // best candidate so far, handed down the chain
  typedef struct packed {
    logic        found;
    logic        side;
    logic [31:0] price;
    logic [31:0] age;
    logic [31:0] remaining;
    logic [63:0] oid;
  } cand_t;

  // slot update broadcast to every cell
  typedef struct packed {
    wr_op_e      op;
    logic [31:0] qty;
    logic [31:0] height;
    logic        side;
    logic [31:0] price;
    logic [31:0] remaining;
    logic [63:0] oid;
    logic [63:0] owner_high;
    logic [63:0] owner_middle;
    logic [31:0] owner_low;
    logic [31:0] expiry;
    logic [31:0] sequence_num;
  } wr_t;

endpackage

// File: sv/lobm_cell.sv
// ----------------------------------------------------------------------------
// lobm_cell
// One book slot: holds a resting order, applies broadcast updates and
// merges itself into the candidate record passing down the chain.
// ----------------------------------------------------------------------------
module lobm_cell
  import lobm_pkg::*;
#(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned INDEX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  key_t             key_i,
  input  logic [31:0]      nseq_i,
  input  wr_t              wr_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  cand_t            cand_i,
  input  logic [IDX_W-1:0] cand_idx_i,
  output cand_t            cand_o,
  output logic [IDX_W-1:0] cand_idx_o
);

  logic        valid_q;
  logic        side_q;
  logic [31:0] price_q;
  logic [31:0] rem_q;
  logic [63:0] id_q;
  logic [63:0] own_h_q;
  logic [63:0] own_m_q;
  logic [31:0] own_l_q;
  logic [31:0] expiry_q;
  logic [31:0] seq_q;

  cand_t            cand_q, cand_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  logic        sel;
  logic [31:0] age;
  logic        qual;
  logic        better;

  assign sel = (wr_idx_i == IDX_W'(INDEX));
  assign age = nseq_i - seq_q;

  always_comb begin
    qual   = 1'b0;
    better = 1'b0;
    case (key_i.mode)
      SCAN_MATCH: begin
        qual = valid_q && (side_q != key_i.side) &&
               (key_i.side ? (price_q >= key_i.limit) : (price_q <= key_i.limit));
        better = key_i.side ? (price_q > cand_i.price) : (price_q < cand_i.price);
        better = better || ((price_q == cand_i.price) && (age > cand_i.age));
      end
      SCAN_CANCEL: begin
        qual = valid_q && (id_q == key_i.oid) && (own_h_q == key_i.owner_high) &&
               (own_m_q == key_i.owner_middle) && (own_l_q == key_i.owner_low);
        if (side_q != cand_i.side) begin
          better = (side_q < cand_i.side);
        end else if (price_q != cand_i.price) begin
          better = (price_q < cand_i.price);
        end else begin
          better = (age > cand_i.age);
        end
      end
      SCAN_FREE: begin
        qual = !valid_q;
      end
      default: begin
        qual = 1'b0;
      end
    endcase
  end

  always_comb begin
    cand_d = cand_i;
    idx_d  = cand_idx_i;
    if (qual && (!cand_i.found || better)) begin
      cand_d.found     = 1'b1;
      cand_d.side      = side_q;
      cand_d.price     = price_q;
      cand_d.age       = age;
      cand_d.remaining = rem_q;
      cand_d.oid       = id_q;
      idx_d            = IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    idx_q  <= idx_d;
  end

  assign cand_o     = cand_q;
  assign cand_idx_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      case (wr_i.op)
        WR_DEC: begin
          if (sel && (rem_q == wr_i.qty)) valid_q <= 1'b0;
        end
        WR_CLEAR: begin
          if (sel) valid_q <= 1'b0;
        end
        WR_LOAD: begin
          if (sel) valid_q <= 1'b1;
        end
        WR_PRUNE: begin
          if (valid_q && (expiry_q != 32'd0) && (expiry_q <= wr_i.height)) valid_q <= 1'b0;
        end
        default: begin
          valid_q <= valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && (wr_i.op == WR_DEC)) begin
      rem_q <= rem_q - wr_i.qty;
    end else if (sel && (wr_i.op == WR_LOAD)) begin
      side_q   <= wr_i.side;
      price_q  <= wr_i.price;
      rem_q    <= wr_i.remaining;
      id_q     <= wr_i.oid;
      own_h_q  <= wr_i.owner_high;
      own_m_q  <= wr_i.owner_middle;
      own_l_q  <= wr_i.owner_low;
      expiry_q <= wr_i.expiry;
      seq_q    <= wr_i.sequence_num;
    end
  end

endmodule

// File: sv/limit_order_book_matcher_top.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top
// Price-time priority order book over a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage: drive the item fields and pulse start while busy is low; the item
// is taken at that edge and busy rises unless the operation is undefined.
// Results come out one per strobe on result_valid_o, each for exactly one
// cycle; last_o marks the final result of an item, and busy is low again
// when it shows. Every search sends one candidate record down the row of
// ORDER_SLOTS cells, one cell per cycle. Place: one search per fill, one
// more that finds nothing (unless the order is used up), and one free-slot
// search if the remainder may rest. Cancel: one search. Prune: no search.
// An undefined operation is dropped with no result.
// Reset empties the book and clears the sequence counter; no clearing pass
// is needed. The receiver cannot stall: results are never held.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_top
  import lobm_pkg::*;
#(
  parameter int unsigned ORDER_SLOTS = DEFAULT_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [63:0] ord_id_i,
  input  logic [63:0] owner_high_i,
  input  logic [63:0] owner_middle_i,
  input  logic [31:0] owner_low_i,
  input  logic        side_i,
  input  logic [31:0] limit_price_i,
  input  logic [31:0] quantity_i,
  input  logic [1:0]  time_in_force_i,
  input  logic [31:0] expiry_i,
  input  logic [31:0] block_height_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [63:0] matched_id_o,
  output logic [31:0] fill_quantity_o,
  output logic [31:0] trade_price_o,
  output logic        rested_o,
  output logic        book_full_o,
  output logic        found_o,
  output logic        last_o
);

  localparam int unsigned IDX_W = $clog2(ORDER_SLOTS);
  localparam int unsigned CNT_W = $clog2(ORDER_SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MATCH  = 7'b0000010,
    S_REST   = 7'b0000100,
    S_FREE   = 7'b0001000,
    S_FINISH = 7'b0010000,
    S_CANCEL = 7'b0100000,
    S_PRUNE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0] nseq_q, nseq_d;

  // latched item
  logic [63:0] id_q, own_h_q, own_m_q;
  logic [31:0] own_l_q, limit_q, expiry_q, height_q;
  logic        side_q;
  logic [1:0]  tif_q;
  logic [31:0] rem_q, rem_d;

  // fill held back until it is known whether it is the last one
  logic        pend_q, pend_d;
  logic [63:0] pend_id_q, pend_id_d;
  logic [31:0] pend_qty_q, pend_qty_d;
  logic [31:0] pend_price_q, pend_price_d;
  logic        rested_q, rested_d;
  logic        full_q, full_d;

  logic        rv_q, rv_d;
  logic [1:0]  kind_q, kind_d;
  logic [63:0] mid_q, mid_d;
  logic [31:0] fq_q, fq_d;
  logic [31:0] fp_q, fp_d;
  logic        rs_q, rs_d;
  logic        bf_q, bf_d;
  logic        fd_q, fd_d;
  logic        last_q, last_d;

  key_t             key;
  wr_t              wr;
  logic [IDX_W-1:0] wr_idx;
  cand_t            cand_w [ORDER_SLOTS+1];
  logic [IDX_W-1:0] idx_w  [ORDER_SLOTS+1];
  cand_t            tail;
  logic [IDX_W-1:0] tail_idx;
  logic             scan_done;
  logic [31:0]      trade_qty;
  logic             accept;

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign scan_done = (cnt_q == CNT_W'(ORDER_SLOTS));
  assign tail      = cand_w[ORDER_SLOTS];
  assign tail_idx  = idx_w[ORDER_SLOTS];
  assign trade_qty = (rem_q < tail.remaining) ? rem_q : tail.remaining;

  always_comb begin
    key.mode         = (state_q == S_CANCEL) ? SCAN_CANCEL :
                       (state_q == S_FREE)   ? SCAN_FREE   : SCAN_MATCH;
    key.side         = side_q;
    key.limit        = limit_q;
    key.oid          = id_q;
    key.owner_high   = own_h_q;
    key.owner_middle = own_m_q;
    key.owner_low    = own_l_q;
  end

  assign cand_w[0] = '0;
  assign idx_w[0]  = '0;

  for (genvar g = 0; g < ORDER_SLOTS; g++) begin : g_cell
    lobm_cell #(
      .IDX_W (IDX_W),
      .INDEX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .key_i      (key),
      .nseq_i     (nseq_q),
      .wr_i       (wr),
      .wr_idx_i   (wr_idx),
      .cand_i     (cand_w[g]),
      .cand_idx_i (idx_w[g]),
      .cand_o     (cand_w[g+1]),
      .cand_idx_o (idx_w[g+1])
    );
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = (cnt_q == CNT_W'(ORDER_SLOTS)) ? cnt_q : cnt_q + CNT_W'(1);
    nseq_d       = nseq_q;
    rem_d        = rem_q;
    pend_d       = pend_q;
    pend_id_d    = pend_id_q;
    pend_qty_d   = pend_qty_q;
    pend_price_d = pend_price_q;
    rested_d     = rested_q;
    full_d       = full_q;

    rv_d   = 1'b0;
    kind_d = KIND_FILL;
    mid_d  = '0;
    fq_d   = '0;
    fp_d   = '0;
    rs_d   = 1'b0;
    bf_d   = 1'b0;
    fd_d   = 1'b0;
    last_d = 1'b0;

    wr              = '0;
    wr.op           = WR_NONE;
    wr.side         = side_q;
    wr.price        = limit_q;
    wr.remaining    = rem_q;
    wr.oid          = id_q;
    wr.owner_high   = own_h_q;
    wr.owner_middle = own_m_q;
    wr.owner_low    = own_l_q;
    wr.expiry       = expiry_q;
    wr.sequence_num = nseq_q;
    wr.height       = height_q;
    wr_idx          = tail_idx;

    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          pend_d   = 1'b0;
          rested_d = 1'b0;
          full_d   = 1'b0;
          rem_d    = quantity_i;
          case (operation_i)
            OP_PLACE:  state_d = (quantity_i == 32'd0) ? S_REST : S_MATCH;
            OP_CANCEL: state_d = S_CANCEL;
            OP_PRUNE:  state_d = S_PRUNE;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_MATCH: begin
        if (scan_done) begin
          cnt_d = '0;
          if (!tail.found) begin
            state_d = S_REST;
          end else begin
            // release the previous fill, hold this one
            if (pend_q) begin
              rv_d   = 1'b1;
              kind_d = KIND_FILL;
              mid_d  = pend_id_q;
              fq_d   = pend_qty_q;
              fp_d   = pend_price_q;
            end
            pend_d       = 1'b1;
            pend_id_d    = tail.oid;
            pend_qty_d   = trade_qty;
            pend_price_d = tail.price;
            wr.op        = WR_DEC;
            wr.qty       = trade_qty;
            rem_d        = rem_q - trade_qty;
            state_d      = (rem_q == trade_qty) ? S_REST : S_MATCH;
          end
        end
      end
      S_REST: begin
        cnt_d   = '0;
        state_d = ((rem_q != 32'd0) && (tif_q != TIF_IOC) && (tif_q != TIF_FOK)) ?
                  S_FREE : S_FINISH;
      end
      S_FREE: begin
        if (scan_done) begin
          if (tail.found) begin
            wr.op    = WR_LOAD;
            nseq_d   = nseq_q + 32'd1;
            rested_d = 1'b1;
          end else begin
            full_d = 1'b1;
          end
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        rv_d   = 1'b1;
        kind_d = pend_q ? KIND_FILL : KIND_NO_FILL;
        if (pend_q) begin
          mid_d = pend_id_q;
          fq_d  = pend_qty_q;
          fp_d  = pend_price_q;
        end
        rs_d    = rested_q;
        bf_d    = full_q;
        last_d  = 1'b1;
        pend_d  = 1'b0;
        state_d = S_IDLE;
      end
      S_CANCEL: begin
        if (scan_done) begin
          if (tail.found) wr.op = WR_CLEAR;
          rv_d    = 1'b1;
          kind_d  = KIND_CANCEL;
          fd_d    = tail.found;
          last_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PRUNE: begin
        wr.op   = WR_PRUNE;
        rv_d    = 1'b1;
        kind_d  = KIND_PRUNE;
        last_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      nseq_q  <= '0;
      pend_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nseq_q  <= nseq_d;
      pend_q  <= pend_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q     <= ord_id_i;
      own_h_q  <= owner_high_i;
      own_m_q  <= owner_middle_i;
      own_l_q  <= owner_low_i;
      side_q   <= side_i;
      limit_q  <= limit_price_i;
      tif_q    <= time_in_force_i;
      expiry_q <= expiry_i;
      height_q <= block_height_i;
    end
    rem_q        <= rem_d;
    pend_id_q    <= pend_id_d;
    pend_qty_q   <= pend_qty_d;
    pend_price_q <= pend_price_d;
    rested_q     <= rested_d;
    full_q       <= full_d;
    kind_q       <= kind_d;
    mid_q        <= mid_d;
    fq_q         <= fq_d;
    fp_q         <= fp_d;
    rs_q         <= rs_d;
    bf_q         <= bf_d;
    fd_q         <= fd_d;
    last_q       <= last_d;
  end

  assign result_valid_o  = rv_q;
  assign kind_o          = kind_q;
  assign matched_id_o    = mid_q;
  assign fill_quantity_o = fq_q;
  assign trade_price_o   = fp_q;
  assign rested_o        = rs_q;
  assign book_full_o     = bf_q;
  assign found_o         = fd_q;
  assign last_o          = last_q;

endmodule

// File: sv/lobm_checker.sv
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks on result sequencing of the order book matcher.
// ----------------------------------------------------------------------------
module lobm_checker
  import lobm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  operation_i,
  input logic        result_valid_o,
  input logic [1:0]  kind_o,
  input logic [63:0] matched_id_o,
  input logic [31:0] fill_quantity_o,
  input logic        last_o
);

  // a non-final result only shows while the item is still in work
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("non-final result while idle");

  // the final result shows once the block is free again
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy)
    else $error("final result while busy");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (operation_i != OP_NONE) |=> busy)
    else $error("item taken but block not busy");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && ((kind_o == KIND_CANCEL) || (kind_o == KIND_PRUNE)) |-> last_o)
    else $error("cancel or prune answer not final");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o != KIND_FILL) |-> (matched_id_o == 64'd0) &&
      (fill_quantity_o == 32'd0))
    else $error("fill fields set on non-fill result");

endmodule

bind limit_order_book_matcher_top lobm_checker u_lobm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .operation_i     (operation_i),
  .result_valid_o  (result_valid_o),
  .kind_o          (kind_o),
  .matched_id_o    (matched_id_o),
  .fill_quantity_o (fill_quantity_o),
  .last_o          (last_o)
);

// File: tb/sv/tb_limit_order_book_matcher_top.sv
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher_top
// Self-checking bench for the limit order book matcher: drives place, cancel,
// prune and undefined commands under random sender gaps, predicts fills and answers
// from a slot table kept alongside the block, and checks every result.
// ----------------------------------------------------------------------------
module tb_limit_order_book_matcher_top;
  import lobm_pkg::*;

  localparam int SLOTS = DEFAULT_SLOTS;
  localparam logic [1:0] TIF_REST  = 2'd0;
  localparam logic [1:0] TIF_THREE = 2'd3;
  localparam int IDLE_LIMIT = 40000;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] id;
    logic [63:0] own_hi;
    logic [63:0] own_mid;
    logic [31:0] own_lo;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [1:0]  tif;
    logic [31:0] expiry;
    logic [31:0] height;
  } order_t;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] id;
    logic [31:0] qty;
    logic [31:0] price;
    logic        rested;
    logic        full;
    logic        found;
    logic        last;
  } fill_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = '0;
  logic [63:0] ord_id_i = '0;
  logic [63:0] owner_high_i = '0;
  logic [63:0] owner_middle_i = '0;
  logic [31:0] owner_low_i = '0;
  logic        side_i = 1'b0;
  logic [31:0] limit_price_i = '0;
  logic [31:0] quantity_i = '0;
  logic [1:0]  time_in_force_i = '0;
  logic [31:0] expiry_i = '0;
  logic [31:0] block_height_i = '0;
  logic        result_valid_o;
  logic [1:0]  kind_o;
  logic [63:0] matched_id_o;
  logic [31:0] fill_quantity_o;
  logic [31:0] trade_price_o;
  logic        rested_o;
  logic        book_full_o;
  logic        found_o;
  logic        last_o;

  // book copy
  logic        bk_valid [SLOTS];
  logic        bk_side  [SLOTS];
  logic [31:0] bk_price [SLOTS];
  logic [31:0] bk_rem   [SLOTS];
  logic [63:0] bk_id    [SLOTS];
  logic [63:0] bk_hi    [SLOTS];
  logic [63:0] bk_mid   [SLOTS];
  logic [31:0] bk_lo    [SLOTS];
  logic [31:0] bk_exp   [SLOTS];
  logic [31:0] bk_seq   [SLOTS];
  logic [31:0] seq_next;

  fill_t  pending_q[$];
  order_t resting_log[$];
  logic [63:0] owner_pool [4][3];
  int errors = 0;
  int send_idle = 0;
  int idle_cycles = 0;

  limit_order_book_matcher_top i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] age_of(int i);
    return seq_next - bk_seq[i];
  endfunction

  function automatic int best_opposite(logic side, logic [31:0] limit);
    int b;
    b = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!bk_valid[i] || bk_side[i] == side) continue;
      if (side == 1'b0 ? bk_price[i] > limit : bk_price[i] < limit) continue;
      if (b < 0) begin
        b = i;
      end else if ((side == 1'b0 ? bk_price[i] < bk_price[b] : bk_price[i] > bk_price[b]) ||
                   (bk_price[i] == bk_price[b] && age_of(i) > age_of(b))) begin
        b = i;
      end
    end
    return b;
  endfunction

  function automatic fill_t blank_result(logic [1:0] kind);
    fill_t r;
    r = '{kind: kind, id: '0, qty: '0, price: '0, rested: 1'b0, full: 1'b0,
          found: 1'b0, last: 1'b1};
    return r;
  endfunction

  function automatic void book_place(order_t it);
    logic [31:0] remaining, q;
    int k, m, f;
    logic rested, full;
    fill_t r;
    remaining = it.qty;
    k = 0;
    while (remaining > 0 && k < SLOTS) begin
      m = best_opposite(it.side, it.price);
      if (m < 0) break;
      q = (remaining < bk_rem[m]) ? remaining : bk_rem[m];
      r = blank_result(KIND_FILL);
      r.id = bk_id[m];
      r.qty = q;
      r.price = bk_price[m];
      r.last = 1'b0;
      pending_q.insert(pending_q.size(), r);
      k++;
      remaining -= q;
      bk_rem[m] -= q;
      if (bk_rem[m] == 0) bk_valid[m] = 1'b0;
    end
    rested = 1'b0;
    full = 1'b0;
    if (remaining > 0 && it.tif != TIF_IOC && it.tif != TIF_FOK) begin
      f = -1;
      for (int i = 0; i < SLOTS; i++)
        if (!bk_valid[i]) begin
          f = i;
          break;
        end
      if (f < 0) begin
        full = 1'b1;
      end else begin
        bk_valid[f] = 1'b1;
        bk_side[f] = it.side;
        bk_price[f] = it.price;
        bk_rem[f] = remaining;
        bk_id[f] = it.id;
        bk_hi[f] = it.own_hi;
        bk_mid[f] = it.own_mid;
        bk_lo[f] = it.own_lo;
        bk_exp[f] = it.expiry;
        bk_seq[f] = seq_next;
        seq_next++;
        rested = 1'b1;
        resting_log.insert(resting_log.size(), it);
        if (resting_log.size() > 48) void'(resting_log.pop_front());
      end
    end
    if (k == 0) begin
      r = blank_result(KIND_NO_FILL);
      r.rested = rested;
      r.full = full;
      pending_q.insert(pending_q.size(), r);
    end else begin
      pending_q[pending_q.size()-1].rested = rested;
      pending_q[pending_q.size()-1].full = full;
      pending_q[pending_q.size()-1].last = 1'b1;
    end
  endfunction

  function automatic void book_cancel(order_t it);
    int hit;
    fill_t r;
    hit = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!bk_valid[i] || bk_id[i] != it.id || bk_hi[i] != it.own_hi ||
          bk_mid[i] != it.own_mid || bk_lo[i] != it.own_lo) continue;
      if (hit < 0) hit = i;
      else if (bk_side[i] != bk_side[hit]) begin
        if (bk_side[i] < bk_side[hit]) hit = i;
      end else if (bk_price[i] != bk_price[hit]) begin
        if (bk_price[i] < bk_price[hit]) hit = i;
      end else if (age_of(i) > age_of(hit)) begin
        hit = i;
      end
    end
    if (hit >= 0) bk_valid[hit] = 1'b0;
    r = blank_result(KIND_CANCEL);
    r.found = (hit >= 0);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic void book_step(order_t it);
    case (it.op)
      OP_PLACE:  book_place(it);
      OP_CANCEL: book_cancel(it);
      OP_PRUNE: begin
        for (int i = 0; i < SLOTS; i++)
          if (bk_valid[i] && bk_exp[i] != 0 && bk_exp[i] <= it.height) bk_valid[i] = 1'b0;
        pending_q.insert(pending_q.size(), blank_result(KIND_PRUNE));
      end
      default: ;
    endcase
  endfunction

  // unused fields carry random noise
  function automatic order_t noise_item();
    order_t it;
    it.op = 2'($urandom_range(3));
    it.id = {$urandom, $urandom};
    it.own_hi = {$urandom, $urandom};
    it.own_mid = {$urandom, $urandom};
    it.own_lo = $urandom;
    it.side = 1'($urandom);
    it.price = $urandom;
    it.qty = $urandom;
    it.tif = 2'($urandom);
    it.expiry = $urandom;
    it.height = $urandom;
    return it;
  endfunction

  function automatic order_t place_item(logic side, logic [31:0] price, logic [31:0] qty,
                                        logic [1:0] tif, logic [31:0] expiry);
    order_t it;
    int o;
    it = noise_item();
    o = $urandom_range(3);
    it.op = OP_PLACE;
    it.id = {56'd0, 8'($urandom)};
    it.own_hi = owner_pool[o][0];
    it.own_mid = owner_pool[o][1];
    it.own_lo = owner_pool[o][2][31:0];
    it.side = side;
    it.price = price;
    it.qty = qty;
    it.tif = tif;
    it.expiry = expiry;
    return it;
  endfunction

  function automatic order_t cancel_item(order_t src);
    order_t it;
    it = noise_item();
    it.op = OP_CANCEL;
    it.id = src.id;
    it.own_hi = src.own_hi;
    it.own_mid = src.own_mid;
    it.own_lo = src.own_lo;
    return it;
  endfunction

  function automatic order_t prune_item(logic [31:0] height);
    order_t it;
    it = noise_item();
    it.op = OP_PRUNE;
    it.height = height;
    return it;
  endfunction

  // call at a rising edge; leaves start high when no gap follows
  task automatic send_item(order_t it);
    int gap;
    operation_i <= it.op;
    ord_id_i <= it.id;
    owner_high_i <= it.own_hi;
    owner_middle_i <= it.own_mid;
    owner_low_i <= it.own_lo;
    side_i <= it.side;
    limit_price_i <= it.price;
    quantity_i <= it.qty;
    time_in_force_i <= it.tif;
    expiry_i <= it.expiry;
    block_height_i <= it.height;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    book_step(it);
    if ($urandom_range(99) < send_idle) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    fill_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual kind %0d", $time, kind_o);
      end else begin
        e = pending_q.pop_front();
        check_field("kind", 64'(e.kind), 64'(kind_o));
        check_field("matched_id", e.id, matched_id_o);
        check_field("fill_quantity", 64'(e.qty), 64'(fill_quantity_o));
        check_field("trade_price", 64'(e.price), 64'(trade_price_o));
        check_field("rested", 64'(e.rested), 64'(rested_o));
        check_field("book_full", 64'(e.full), 64'(book_full_o));
        check_field("found", 64'(e.found), 64'(found_o));
        check_field("last", 64'(e.last), 64'(last_o));
      end
    end
  end

  // count cycles in which no item and no result moves
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("limit_order_book_matcher_top: mismatch");
      $finish;
    end
  end

  task automatic test_basic();
    send_item(place_item(1'b0, 32'd100, 32'd10, TIF_REST, 32'd0));
    send_item(place_item(1'b0, 32'd100, 32'd5, TIF_REST, 32'd0));
    send_item(place_item(1'b0, 32'd101, 32'd7, TIF_REST, 32'd0));
    // sell crosses best bid first, then oldest at 100
    send_item(place_item(1'b1, 32'd100, 32'd20, TIF_REST, 32'd0));
    send_item(place_item(1'b0, 32'd0, 32'd0, TIF_REST, 32'd0));
    send_item(place_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIF_REST, 32'd0));
    send_item(place_item(1'b0, 32'hFFFF_FFFF, 32'd3, TIF_REST, 32'hFFFF_FFFF));
    send_item(place_item(1'b1, 32'd0, 32'd1, TIF_REST, 32'd0));
    send_item(place_item(1'b0, 32'd0, 32'd9, TIF_REST, 32'd0));
    send_item(place_item(1'b1, 32'd0, 32'hFFFF_FFFF, TIF_IOC, 32'd0));
  endtask

  task automatic test_time_in_force();
    order_t it;
    send_item(place_item(1'b1, 32'd50, 32'd4, TIF_REST, 32'd0));
    send_item(place_item(1'b0, 32'd60, 32'd10, TIF_IOC, 32'd0));
    send_item(place_item(1'b0, 32'd40, 32'd10, TIF_FOK, 32'd0));
    send_item(place_item(1'b0, 32'd40, 32'd10, TIF_THREE, 32'd0));
    send_item(place_item(1'b1, 32'd40, 32'd10, TIF_IOC, 32'd0));
    it = noise_item();
    it.op = OP_NONE;
    send_item(it);
  endtask

  task automatic test_full_book();
    // bids only, so nothing crosses and at least the last one finds the book full
    for (int i = 0; i < SLOTS + 1; i++)
      send_item(place_item(1'b0, 32'd7 + 32'($urandom_range(1)), 32'd2, TIF_REST, 32'd0));
    // sweep every resting order: bids with a low sell, asks with a high buy
    send_item(place_item(1'b1, 32'd0, 32'hFFFF_FFFF, TIF_IOC, 32'd0));
    send_item(place_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIF_IOC, 32'd0));
  endtask

  task automatic test_cancel_prune();
    order_t a, b;
    a = place_item(1'b1, 32'd300, 32'd5, TIF_REST, 32'd20);
    b = a;
    b.side = 1'b0;
    b.price = 32'd200;
    send_item(a);
    send_item(b);
    send_item(b);
    send_item(cancel_item(a));
    send_item(cancel_item(a));
    send_item(cancel_item(a));
    send_item(cancel_item(a));
    send_item(place_item(1'b0, 32'd10, 32'd5, TIF_REST, 32'd30));
    send_item(place_item(1'b1, 32'd10, 32'd2, TIF_REST, 32'd0));
    send_item(prune_item(32'd29));
    send_item(prune_item(32'd30));
    send_item(prune_item(32'hFFFF_FFFF));
  endtask

  task automatic test_random(int count);
    order_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        it = place_item(1'($urandom), 32'd1000 + 32'($urandom_range(16)) - 32'd8,
                        ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(1, 40)),
                        2'($urandom), ($urandom_range(1) == 0) ? 32'd0 :
                        32'($urandom_range(1, 200)));
        if ($urandom_range(15) == 0) it.qty = $urandom;
      end else if (pick < 80) begin
        if (resting_log.size() > 0 && $urandom_range(4) != 0)
          it = cancel_item(resting_log[$urandom_range(resting_log.size() - 1)]);
        else begin
          it = noise_item();
          it.op = OP_CANCEL;
        end
      end else if (pick < 90) begin
        it = prune_item(($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(250)));
      end else begin
        it = noise_item();
      end
      send_item(it);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) bk_valid[i] = 1'b0;
    seq_next = '0;
    for (int o = 0; o < 4; o++)
      for (int w = 0; w < 3; w++) owner_pool[o][w] = {$urandom, $urandom};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 25;
    test_basic();
    test_time_in_force();
    test_full_book();
    test_cancel_prune();
    test_random(35);
    send_idle = 77;
    test_random(35);
    send_idle = 0;
    test_random(35);
    start <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("limit_order_book_matcher_top: match");
    end else begin
      $display("limit_order_book_matcher_top: mismatch");
    end
    $finish;
  end

endmodule
